### rtl/core/mvp_pkg.sv
// ----------------------------------------------------------------------------
// Matrix-vector product package
// Shared widths, codes and the token that runs along the chain of row cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mvp_pkg;

  localparam int DataW    = 32;
  localparam int ProdW    = 64;
  localparam int AccW     = 68;
  localparam int FracW    = 16;
  localparam int IdxW     = 4;
  localparam int CountW   = 5;
  localparam int ActW     = 2;
  localparam int CfgIdxW  = 1;
  localparam int CountLim = 16;

  localparam int MaxRowsDef = 16;
  localparam int MaxColsDef = 16;

  localparam logic [ActW-1:0] ACT_LOAD_MATRIX = 2'd0;
  localparam logic [ActW-1:0] ACT_LOAD_VECTOR = 2'd1;
  localparam logic [ActW-1:0] ACT_COMPUTE     = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_ROWS = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_COLS = 1'b1;

  localparam logic [CountW-1:0] CountReset = 5'd16;

  typedef struct packed {
    logic                    valid;
    logic [IdxW-1:0]         col;
    logic signed [DataW-1:0] x;
    logic                    first;
    logic                    last;
  } token_t;

endpackage

`default_nettype wire

### rtl/core/matrix_vector_product_top.sv
// ----------------------------------------------------------------------------
// Matrix-vector product
// Signed Q16.16 matrix-vector multiply over a chain of row cells.
// ----------------------------------------------------------------------------
// Items are given on start_i while busy_o is low. Loads of matrix entries and
// vector elements keep busy_o low, so one may follow in every cycle. A compute
// item raises busy_o; the vector is read one element a cycle and travels down
// the chain, one cell per row, each cell multiplying it by its own stored row
// and keeping the exact sum. Cell r finishes in the cycle after cell r-1, so
// results leave on result_valid_o one a cycle, row 0 first, the last marked
// by last_o. busy_o stays high until the whole chain has drained, for a time
// set by the column walk and the chain length.
// Each result beat is shown for exactly one cycle; the receiver cannot stall.
// Configuration writes on cfg_we_i take effect at once and belong to idle time.
// Reset sets both counts to sixteen and empties the pipeline; the stores hold
// nothing defined until they are loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_vector_product_top #(
  parameter int MaxRows = mvp_pkg::MaxRowsDef,
  parameter int MaxCols = mvp_pkg::MaxColsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [mvp_pkg::ActW-1:0]         action_i,
  input  wire logic [mvp_pkg::IdxW-1:0]         row_index_i,
  input  wire logic [mvp_pkg::IdxW-1:0]         col_index_i,
  input  wire logic signed [mvp_pkg::DataW-1:0] value_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [mvp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [mvp_pkg::CountW-1:0]       cfg_wdata_i,
  output logic                                  result_valid_o,
  output logic [mvp_pkg::IdxW-1:0]              result_row_o,
  output logic signed [mvp_pkg::DataW-1:0]      result_value_o,
  output logic                                  saturated_o,
  output logic                                  last_o
);

  localparam int NumCells = (MaxRows < mvp_pkg::CountLim) ? MaxRows : mvp_pkg::CountLim;
  localparam int ColDepth = (MaxCols < mvp_pkg::CountLim) ? MaxCols : mvp_pkg::CountLim;
  localparam int ColAw    = (ColDepth > 1) ? $clog2(ColDepth) : 1;
  localparam int HiW      = mvp_pkg::AccW - mvp_pkg::FracW - mvp_pkg::DataW + 1;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FLUSH} state_e;

  state_e                                state_q;
  logic [mvp_pkg::IdxW-1:0]              col_q;
  logic                                  rd_v_q;
  logic [mvp_pkg::IdxW-1:0]              rd_col_q;
  logic                                  rd_first_q;
  logic                                  rd_last_q;

  logic [mvp_pkg::CountW-1:0]            rows_q;
  logic [mvp_pkg::CountW-1:0]            cols_q;
  logic [mvp_pkg::CountW-1:0]            rows_used;
  logic [mvp_pkg::CountW-1:0]            cols_used;

  logic                                  accept;
  logic                                  compute;
  logic                                  col_ok;
  logic                                  vec_we;
  logic [mvp_pkg::DataW-1:0]             vec_rdata;

  mvp_pkg::token_t                       tok_in  [NumCells];
  mvp_pkg::token_t                       tok_out [NumCells];
  logic [NumCells-1:0]                   done;
  logic signed [mvp_pkg::AccW-1:0]       acc     [NumCells];

  logic [NumCells-1:0]                   live_done;
  logic [mvp_pkg::AccW-1:0]              sel;
  logic                                  emit;
  logic [mvp_pkg::IdxW-1:0]              cnt_q;
  logic                                  emit_q;
  logic [mvp_pkg::AccW-1:0]              sel_q;
  logic [mvp_pkg::IdxW-1:0]              row_m_q;
  logic                                  last_m_q;

  logic [HiW-1:0]                        hi_bits;
  logic                                  fits;
  logic signed [mvp_pkg::DataW-1:0]      value_d;

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign compute = accept && (action_i == mvp_pkg::ACT_COMPUTE);
  assign col_ok  = (int'(col_index_i) < MaxCols);
  assign vec_we  = accept && (action_i == mvp_pkg::ACT_LOAD_VECTOR) && col_ok;

  always_comb begin
    if (rows_q == '0) begin
      rows_used = mvp_pkg::CountW'(1);
    end else if (rows_q > mvp_pkg::CountW'(NumCells)) begin
      rows_used = mvp_pkg::CountW'(NumCells);
    end else begin
      rows_used = rows_q;
    end
    if (cols_q == '0) begin
      cols_used = mvp_pkg::CountW'(1);
    end else if (cols_q > mvp_pkg::CountW'(ColDepth)) begin
      cols_used = mvp_pkg::CountW'(ColDepth);
    end else begin
      cols_used = cols_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= mvp_pkg::CountReset;
      cols_q <= mvp_pkg::CountReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mvp_pkg::REG_ROWS) begin
        rows_q <= cfg_wdata_i;
      end else if (cfg_idx_i == mvp_pkg::REG_COLS) begin
        cols_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      col_q      <= '0;
      rd_v_q     <= 1'b0;
      rd_col_q   <= '0;
      rd_first_q <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      rd_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          col_q <= '0;
          if (compute) begin
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          rd_v_q     <= 1'b1;
          rd_col_q   <= col_q;
          rd_first_q <= (col_q == '0);
          rd_last_q  <= ({1'b0, col_q} == cols_used - 5'd1);
          if ({1'b0, col_q} == cols_used - 5'd1) begin
            state_q <= S_WAIT;
          end else begin
            col_q <= col_q + 4'd1;
          end
        end
        S_WAIT: begin
          if (done[NumCells-1]) begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  mvp_ram #(
    .Width (mvp_pkg::DataW),
    .Depth (ColDepth),
    .AddrW (ColAw)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (ColAw'(col_index_i)),
    .wdata_i (value_i),
    .raddr_i (ColAw'(col_q)),
    .rdata_o (vec_rdata)
  );

  assign tok_in[0] = '{valid: rd_v_q, col: rd_col_q, x: $signed(vec_rdata),
                       first: rd_first_q, last: rd_last_q};

  for (genvar r = 0; r < NumCells; r++) begin : g_cell
    if (r > 0) begin : g_link
      assign tok_in[r] = tok_out[r-1];
    end

    mvp_cell #(
      .ColDepth (ColDepth),
      .AddrW    (ColAw)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .we_i    (accept && (action_i == mvp_pkg::ACT_LOAD_MATRIX) && col_ok &&
                (int'(row_index_i) == r)),
      .wcol_i  (col_index_i),
      .wdata_i (value_i),
      .token_i (tok_in[r]),
      .token_o (tok_out[r]),
      .done_o  (done[r]),
      .acc_o   (acc[r])
    );
  end

  always_comb begin
    sel = '0;
    for (int r = 0; r < NumCells; r++) begin
      live_done[r] = done[r] && (r < int'(rows_used));
      sel = sel | ({mvp_pkg::AccW{live_done[r]}} & acc[r]);
    end
    emit = |live_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      emit_q <= 1'b0;
    end else begin
      emit_q <= emit;
      if (compute) begin
        cnt_q <= '0;
      end else if (emit) begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q    <= sel;
    row_m_q  <= cnt_q;
    last_m_q <= ({1'b0, cnt_q} == rows_used - 5'd1);
  end

  assign hi_bits = sel_q[mvp_pkg::AccW-1 -: HiW];
  assign fits    = (hi_bits == '0) || (hi_bits == '1);

  always_comb begin
    if (fits) begin
      value_d = $signed(sel_q[mvp_pkg::FracW +: mvp_pkg::DataW]);
    end else if (sel_q[mvp_pkg::AccW-1]) begin
      value_d = $signed(32'h8000_0000);
    end else begin
      value_d = $signed(32'h7FFF_FFFF);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_row_o   <= row_m_q;
    result_value_o <= value_d;
    saturated_o    <= !fits;
    last_o         <= last_m_q;
  end

endmodule

`default_nettype wire

### rtl/core/mvp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mvp_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/mvp_cell.sv
// ----------------------------------------------------------------------------
// Matrix-vector product row cell
// Holds one matrix row, multiplies it by the passing vector elements and
// accumulates the exact dot product; the token moves on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mvp_cell #(
  parameter int ColDepth = 16,
  parameter int AddrW    = (ColDepth > 1) ? $clog2(ColDepth) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              we_i,
  input  wire logic [mvp_pkg::IdxW-1:0]          wcol_i,
  input  wire logic [mvp_pkg::DataW-1:0]         wdata_i,
  input  wire mvp_pkg::token_t                   token_i,
  output mvp_pkg::token_t                        token_o,
  output logic                                   done_o,
  output logic signed [mvp_pkg::AccW-1:0]        acc_o
);

  mvp_pkg::token_t                     token_q;
  logic [mvp_pkg::DataW-1:0]           entry;
  logic signed [mvp_pkg::ProdW-1:0]    prod_q;
  logic                                prod_v_q;
  logic                                prod_first_q;
  logic                                prod_last_q;
  logic signed [mvp_pkg::AccW-1:0]     prod_ext;
  logic signed [mvp_pkg::AccW-1:0]     acc_d;
  logic signed [mvp_pkg::AccW-1:0]     acc_q;
  logic                                done_q;

  mvp_ram #(
    .Width (mvp_pkg::DataW),
    .Depth (ColDepth),
    .AddrW (AddrW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (AddrW'(wcol_i)),
    .wdata_i (wdata_i),
    .raddr_i (AddrW'(token_i.col)),
    .rdata_o (entry)
  );

  assign prod_ext = {{(mvp_pkg::AccW - mvp_pkg::ProdW){prod_q[mvp_pkg::ProdW-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (prod_v_q) begin
      acc_d = prod_first_q ? prod_ext : acc_q + prod_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q  <= '0;
      prod_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      token_q  <= token_i;
      prod_v_q <= token_q.valid;
      done_q   <= prod_v_q && prod_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= $signed(entry) * token_q.x;
    prod_first_q <= token_q.first;
    prod_last_q  <= token_q.last;
    acc_q        <= acc_d;
  end

  assign token_o = token_q;
  assign done_o  = done_q;
  assign acc_o   = acc_q;

endmodule

`default_nettype wire

### rtl/core/mvp_checker.sv
// ----------------------------------------------------------------------------
// Matrix-vector product port checker
// Watches the top level's ports for command and result ordering slips and for clipped values off the limits.
// ----------------------------------------------------------------------------
`default_nettype none

module mvp_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start_i,
  input wire logic                         busy_o,
  input wire logic [mvp_pkg::ActW-1:0]     action_i,
  input wire logic                         result_valid_o,
  input wire logic [mvp_pkg::DataW-1:0]    result_value_o,
  input wire logic                         saturated_o,
  input wire logic                         last_o
);

  a_compute_sets_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (action_i == mvp_pkg::ACT_COMPUTE)) |=> busy_o)
    else $error("compute beat did not raise busy");

  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("result beat followed the last one");

  a_result_needs_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result beat outside a run");

  a_clip_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && saturated_o) |->
      ((result_value_o == 32'h7FFF_FFFF) || (result_value_o == 32'h8000_0000)))
    else $error("clipped result is not a limit value");

endmodule

bind matrix_vector_product_top mvp_checker u_mvp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .action_i       (action_i),
  .result_valid_o (result_valid_o),
  .result_value_o (result_value_o),
  .saturated_o    (saturated_o),
  .last_o         (last_o)
);

`default_nettype wire

### tb/sv/tb_matrix_vector_product_top.sv
// ----------------------------------------------------------------------------
// Matrix-vector product testbench
// Loads matrices and vectors in Q16.16, requests products and checks every
// result beat against row sums modelled in the testbench or given by hand. A
// table of hand-picked beats comes first, then random load and compute
// sequences under changing row and column counts, mostly with random input gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix_vector_product_top;
  import mvp_pkg::*;

  localparam logic [ActW-1:0] ACT_RESERVED = 2'd3;

  localparam int SettleCycles = 8;
  localparam int TailCycles   = 40;
  localparam int QuietLimit   = 2000;
  localparam int RandomBeats  = 160;

  localparam logic signed [71:0] SumMax = 72'sh7FFF_FFFF;
  localparam logic signed [71:0] SumMin = -72'sh8000_0000;

  typedef struct packed {
    logic [ActW-1:0]         act;
    logic [IdxW-1:0]         row;
    logic [IdxW-1:0]         col;
    logic signed [DataW-1:0] val;
  } beat_t;

  typedef struct packed {
    logic [IdxW-1:0]         row;
    logic signed [DataW-1:0] value;
    logic                    sat;
    logic                    last;
  } row_product_t;

  typedef struct {
    logic                    set_counts;
    logic [CountW-1:0]       rows;
    logic [CountW-1:0]       cols;
    beat_t                   beat;
    logic                    typed;
    logic signed [DataW-1:0] typed_value;
    logic                    typed_sat;
  } step_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    start_i     = 1'b0;
  logic [ActW-1:0]         action_i    = '0;
  logic [IdxW-1:0]         row_index_i = '0;
  logic [IdxW-1:0]         col_index_i = '0;
  logic signed [DataW-1:0] value_i     = '0;
  logic                    cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i   = '0;
  logic [CountW-1:0]       cfg_wdata_i = '0;
  logic                    busy_o;
  logic                    result_valid_o;
  logic [IdxW-1:0]         result_row_o;
  logic signed [DataW-1:0] result_value_o;
  logic                    saturated_o;
  logic                    last_o;

  logic signed [DataW-1:0] matrix_q [MaxRowsDef][MaxColsDef];
  logic signed [DataW-1:0] vector_q [MaxColsDef];
  bit                      matrix_loaded [MaxRowsDef][MaxColsDef];
  bit                      vector_loaded [MaxColsDef];
  logic [CountW-1:0]       rows_reg = CountReset;
  logic [CountW-1:0]       cols_reg = CountReset;

  row_product_t expected_products [$];
  step_t        directed_steps [$];

  int mismatches    = 0;
  int beats_in      = 0;
  int computes_in   = 0;
  int products_seen = 0;
  int count_writes  = 0;
  int quiet_cycles  = 0;
  bit gaps_on       = 1'b1;

  matrix_vector_product_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .value_i        (value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_row_o   (result_row_o),
    .result_value_o (result_value_o),
    .saturated_o    (saturated_o),
    .last_o         (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int used_count(input logic [CountW-1:0] setting);
    if (setting == '0) return 1;
    if (setting > CountLim) return CountLim;
    return int'(setting);
  endfunction

  function automatic beat_t make_beat(input logic [ActW-1:0] act, input int row, input int col,
                                      input logic signed [DataW-1:0] val);
    beat_t b;
    b.act = act;
    b.row = IdxW'(row);
    b.col = IdxW'(col);
    b.val = val;
    return b;
  endfunction

  function automatic logic signed [DataW-1:0] random_value();
    case ($urandom_range(5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(32'h1F_FFFF)) - 32'h10_0000;
      4:       return 32'($urandom_range(32'h4_0000));
      default: return $urandom();
    endcase
  endfunction

  // Exact sums of Q32.32 products, floored back to Q16.16 and clipped.
  function automatic void predict_row_products();
    logic signed [71:0] acc;
    logic signed [71:0] scaled;
    row_product_t       res;
    int                 nr;
    int                 nc;
    nr = used_count(rows_reg);
    nc = used_count(cols_reg);
    for (int r = 0; r < nr; r++) begin
      acc = '0;
      for (int c = 0; c < nc; c++) acc = acc + matrix_q[r][c] * vector_q[c];
      scaled    = acc >>> FracW;
      res.row   = IdxW'(r);
      res.last  = (r == nr - 1);
      if (scaled > SumMax) begin
        res.value = 32'h7FFF_FFFF;
        res.sat   = 1'b1;
      end else if (scaled < SumMin) begin
        res.value = 32'h8000_0000;
        res.sat   = 1'b1;
      end else begin
        res.value = scaled[DataW-1:0];
        res.sat   = 1'b0;
      end
      expected_products.push_back(res);
    end
  endfunction

  function automatic void track_beat(input beat_t b);
    case (b.act)
      ACT_LOAD_MATRIX: begin
        matrix_q[b.row][b.col]      = b.val;
        matrix_loaded[b.row][b.col] = 1'b1;
      end
      ACT_LOAD_VECTOR: begin
        vector_q[b.col]      = b.val;
        vector_loaded[b.col] = 1'b1;
      end
      ACT_COMPUTE: predict_row_products();
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    if (mismatches < 40)
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_beat(input beat_t b, input logic typed,
                           input logic signed [DataW-1:0] typed_value, input logic typed_sat);
    row_product_t res;
    while (gaps_on && $urandom_range(99) < 8) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    action_i    <= b.act;
    row_index_i <= b.row;
    col_index_i <= b.col;
    value_i     <= b.val;
    do @(posedge clk_i); while (busy_o);
    if (b.act != ACT_RESERVED) beats_in++;
    if (b.act == ACT_COMPUTE) computes_in++;
    if (typed && b.act == ACT_COMPUTE) begin
      res.row   = '0;
      res.value = typed_value;
      res.sat   = typed_sat;
      res.last  = 1'b1;
      expected_products.push_back(res);
    end else begin
      track_beat(b);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (expected_products.size() != 0 || busy_o) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_counts(input logic [CountW-1:0] rows, input logic [CountW-1:0] cols);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_ROWS;
    cfg_wdata_i <= rows;
    @(posedge clk_i);
    cfg_idx_i   <= REG_COLS;
    cfg_wdata_i <= cols;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rows_reg     = rows;
    cols_reg     = cols;
    count_writes++;
  endtask

  task automatic add_counts(input logic [CountW-1:0] rows, input logic [CountW-1:0] cols);
    step_t s;
    s = '{default: '0};
    s.set_counts = 1'b1;
    s.rows       = rows;
    s.cols       = cols;
    directed_steps.push_back(s);
  endtask

  task automatic add_beat(input logic [ActW-1:0] act, input int row, input int col,
                          input logic signed [DataW-1:0] val);
    step_t s;
    s = '{default: '0};
    s.beat = make_beat(act, row, col, val);
    directed_steps.push_back(s);
  endtask

  // Compute with a single row in use, so the one result is known by hand.
  task automatic add_checked(input logic signed [DataW-1:0] value, input logic sat);
    step_t s;
    s = '{default: '0};
    s.beat        = make_beat(ACT_COMPUTE, $urandom_range(15), $urandom_range(15), $urandom());
    s.typed       = 1'b1;
    s.typed_value = value;
    s.typed_sat   = sat;
    directed_steps.push_back(s);
  endtask

  task automatic run_phase(input logic [CountW-1:0] rows_cfg, input logic [CountW-1:0] cols_cfg,
                           input int computes);
    beat_t plan [$];
    beat_t tmp;
    int    nr;
    int    nc;
    int    j;
    write_counts(rows_cfg, cols_cfg);
    nr = used_count(rows_cfg);
    nc = used_count(cols_cfg);
    repeat (computes) begin
      plan.delete();
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nc; c++)
          if (!matrix_loaded[r][c])
            plan.push_back(make_beat(ACT_LOAD_MATRIX, r, c, random_value()));
      for (int c = 0; c < nc; c++)
        if (!vector_loaded[c]) plan.push_back(make_beat(ACT_LOAD_VECTOR, 0, c, random_value()));
      repeat ($urandom_range(3))
        plan.push_back(make_beat(ACT_LOAD_MATRIX, $urandom_range(nr - 1), $urandom_range(nc - 1),
                                 random_value()));
      repeat ($urandom_range(2))
        plan.push_back(make_beat(ACT_LOAD_VECTOR, $urandom_range(15), $urandom_range(nc - 1),
                                 random_value()));
      repeat ($urandom_range(2))
        plan.push_back(make_beat(ActW'($urandom_range(1)), $urandom_range(15),
                                 $urandom_range(15), random_value()));
      if ($urandom_range(4) == 0)
        plan.push_back(make_beat(ACT_RESERVED, $urandom_range(15), $urandom_range(15),
                                 $urandom()));
      for (int i = plan.size() - 1; i > 0; i--) begin
        j       = $urandom_range(i);
        tmp     = plan[i];
        plan[i] = plan[j];
        plan[j] = tmp;
      end
      foreach (plan[i]) send_beat(plan[i], 1'b0, '0, 1'b0);
      send_beat(make_beat(ACT_COMPUTE, $urandom_range(15), $urandom_range(15), $urandom()),
                1'b0, '0, 1'b0);
      if ($urandom_range(2) == 0) drain_results();
    end
  endtask

  always @(posedge clk_i) begin
    row_product_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_products.size() == 0) begin
        report_mismatch("result beat with no product pending", result_value_o, '0);
      end else begin
        want = expected_products.pop_front();
        products_seen++;
        if (result_row_o !== want.row)
          report_mismatch("result_row", DataW'(result_row_o), DataW'(want.row));
        if (result_value_o !== want.value)
          report_mismatch("result_value", result_value_o, want.value);
        if (saturated_o !== want.sat)
          report_mismatch("saturated", DataW'(saturated_o), DataW'(want.sat));
        if (last_o !== want.last)
          report_mismatch("last", DataW'(last_o), DataW'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("[%0t] no beat moved for %0d cycles", $realtime, QuietLimit);
      $display("tb_matrix_vector_product_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int target;

    add_counts(5'd1, 5'd1);
    add_beat(ACT_LOAD_MATRIX, 0, 0, 32'h7FFF_FFFF);
    add_beat(ACT_LOAD_VECTOR, 0, 0, 32'h7FFF_FFFF);
    add_checked(32'h7FFF_FFFF, 1'b1);
    add_beat(ACT_LOAD_MATRIX, 0, 0, 32'h8000_0000);
    add_checked(32'h8000_0000, 1'b1);
    add_beat(ACT_LOAD_VECTOR, 0, 0, 32'h8000_0000);
    add_checked(32'h7FFF_FFFF, 1'b1);
    add_beat(ACT_LOAD_MATRIX, 0, 0, 32'h0001_0000);
    add_beat(ACT_LOAD_VECTOR, 0, 0, 32'h0001_0000);
    add_checked(32'h0001_0000, 1'b0);
    // The smallest negative product must floor to minus one LSB, not to zero.
    add_beat(ACT_LOAD_MATRIX, 0, 0, 32'h0000_0001);
    add_beat(ACT_LOAD_VECTOR, 0, 0, 32'hFFFF_FFFF);
    add_checked(32'hFFFF_FFFF, 1'b0);
    add_beat(ACT_RESERVED, 15, 15, 32'hFFFF_FFFF);
    add_checked(32'hFFFF_FFFF, 1'b0);
    add_beat(ACT_LOAD_MATRIX, 15, 15, 32'h1234_5678);
    add_beat(ACT_LOAD_VECTOR, 0, 15, 32'hFEDC_BA98);
    add_counts(5'd0, 5'd2);
    add_beat(ACT_LOAD_MATRIX, 0, 1, 32'h0002_0000);
    add_beat(ACT_LOAD_VECTOR, 0, 1, 32'h0003_0000);
    add_beat(ACT_COMPUTE, 0, 0, 32'h0);
    add_counts(5'd2, 5'd0);
    add_beat(ACT_LOAD_MATRIX, 1, 0, 32'hFFFF_0000);
    add_beat(ACT_COMPUTE, 15, 15, 32'hFFFF_FFFF);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].set_counts)
        write_counts(directed_steps[i].rows, directed_steps[i].cols);
      else
        send_beat(directed_steps[i].beat, directed_steps[i].typed,
                  directed_steps[i].typed_value, directed_steps[i].typed_sat);
    end

    target = RandomBeats;
    run_phase(5'd31, 5'd0, 2);
    run_phase(5'd0, 5'd31, 2);
    gaps_on = 1'b0;
    run_phase(5'd16, 5'd2, 2);
    run_phase(5'd2, 5'd17, 2);
    gaps_on = 1'b1;
    while (beats_in < target)
      run_phase(CountW'($urandom_range(6)), CountW'($urandom_range(6)), $urandom_range(3, 1));

    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("Run covered %0d input beats, %0d of them product requests, and %0d result beats.",
             beats_in, computes_in, products_seen);
    $display("Row and column counts were set %0d times, from zero up to the top of the field.",
             count_writes);
    if (mismatches == 0) begin
      $display("tb_matrix_vector_product_top: PASS");
    end else begin
      $display("tb_matrix_vector_product_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
